// File: rtl/assert_macros.svh
// Assertion macros used by rtl/mark_sweep_heap_allocator.sv.
// No dependencies; the user must provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/msha_pkg.sv
// Constants, header layout and helper functions of the mark-sweep heap allocator.
// No dependencies.
package msha_pkg;

  localparam int HEAP_WORDS     = 4096;
  localparam int MIN_FREE_WORDS = 4;
  localparam int HEADER_WORDS   = 1;

  localparam int AW  = $clog2(HEAP_WORDS);
  localparam int LW  = AW + 1;
  localparam int SZW = 21;

  localparam int EXTRA_LSB = 21;
  localparam int TYPE_LSB  = 42;
  localparam int MARK_POS  = 50;
  localparam int LINK_POS  = 32;

  localparam logic [7:0]  FREE_TYPE = 8'hff;
  localparam logic [63:0] LINK_END  = 64'd1 << LINK_POS;
  localparam logic [63:0] MARK_MASK = 64'd1 << MARK_POS;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EXHAUST = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_ENABLE    = 1'b1;

  function automatic logic [63:0] compose(input logic [LW-1:0] size,
                                          input logic [LW-1:0] extra,
                                          input logic [7:0]    ctype);
    compose = {14'd0, ctype, SZW'(extra), SZW'(size)};
  endfunction

  // cell length, clamped to the heap end
  function automatic logic [LW-1:0] cell_len(input logic [63:0]   hdr,
                                             input logic [AW-1:0] idx);
    logic [LW-1:0]  room;
    logic [SZW-1:0] s;
    room = LW'(HEAP_WORDS) - {1'b0, idx};
    s    = hdr[SZW-1:0];
    if (s == '0 || s > SZW'(room)) return room;
    return s[LW-1:0];
  endfunction

  localparam logic [63:0] HDR_INIT = compose(LW'(HEAP_WORDS), '0, FREE_TYPE);

endpackage

// File: rtl/mark_sweep_heap_allocator.sv
// Mark-sweep heap allocator: first-fit free list over a 4096 x 64 heap memory.
// Allocate reads header and link of each free chunk visited; mark reads one header and sets
// its mark bit if clear, or answers at once outside the heap; sweep reads every header and
// rewrites each unmarked run; reinitialize reruns the clearing pass. One request at a time,
// set by the walk over the heap memory; the result register lets the next request enter while
// a result waits. Reset (sync, active low) runs a clearing pass over the heap, in_tready held low.
`include "assert_macros.svh"

module mark_sweep_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], alloc_bytes[16:2], cell_type[24:17],
                                  // cell_addr[37:25], zero[39:38]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[1:0], payload_addr[13:2], already_marked[14],
                                  // free_words[27:15], gc_needed[28], zero[31:29]
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [12:0] cfg_wdata
);
  import msha_pkg::*;

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001, S_IDLE  = 15'h0002, S_A_HDR = 15'h0004, S_A_LNK = 15'h0008,
    S_A_EV  = 15'h0010, S_A_WR2 = 15'h0020, S_M_RD  = 15'h0040, S_M_WR  = 15'h0080,
    S_W_RD  = 15'h0100, S_W_EV  = 15'h0200, S_R1    = 15'h0400, S_R2    = 15'h0800,
    S_R3    = 15'h1000, S_W_FIN = 15'h2000, S_DONE  = 15'h4000
  } state_t;

  logic [63:0] heap_mem [HEAP_WORDS];
  logic [63:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [63:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) heap_mem[mem_wa] <= mem_wd;
    rd_data <= heap_mem[mem_ra];
  end

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic clr_op_r, clr_op_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic empty_r, empty_nxt;
  logic [LW-1:0] free_r, free_nxt;
  logic [12:0] thr_r, thr_nxt;
  logic gc_en_r, gc_en_nxt;
  logic [LW-1:0] need_r, need_nxt;
  logic [7:0] type_r, type_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic prev_v_r, prev_v_nxt;
  logic [LW-1:0] steps_r, steps_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] sz_r, sz_nxt;
  logic [LW-1:0] ex_r, ex_nxt;
  logic [LW-1:0] scan_r, scan_nxt;
  logic ph_r, ph_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [63:0] last_hdr_r, last_hdr_nxt;
  logic [LW-1:0] last_len_r, last_len_nxt;
  logic last_v_r, last_v_nxt;
  logic [LW-1:0] start_r, start_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic tail_v_r, tail_v_nxt;
  logic [LW-1:0] total_r, total_nxt;
  logic [1:0] st_r, st_nxt;
  logic [AW-1:0] pay_r, pay_nxt;
  logic mk_r, mk_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic [1:0]  in_op;
  logic [14:0] in_bytes;
  logic [7:0]  in_type;
  logic [12:0] in_addr;
  assign in_op    = in_tdata[1:0];
  assign in_bytes = in_tdata[16:2];
  assign in_type  = in_tdata[24:17];
  assign in_addr  = in_tdata[37:25];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic          has_next;
  logic [LW-1:0] steps_inc, rest, w_len, w_adv, run, e13, lm1, sub_n;
  logic [15:0]   bytes_rnd;
  logic [63:0]   hdr_clr;
  logic          split;

  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;  clr_op_nxt = clr_op_r;
    head_nxt = head_r;  empty_nxt = empty_r;  free_nxt = free_r;
    thr_nxt = thr_r;  gc_en_nxt = gc_en_r;
    need_nxt = need_r;  type_nxt = type_r;  addr_nxt = addr_r;
    cur_nxt = cur_r;  prev_nxt = prev_r;  prev_v_nxt = prev_v_r;  steps_nxt = steps_r;
    hdr_nxt = hdr_r;  len_nxt = len_r;  sz_nxt = sz_r;  ex_nxt = ex_r;
    scan_nxt = scan_r;  ph_nxt = ph_r;  last_nxt = last_r;  last_hdr_nxt = last_hdr_r;
    last_len_nxt = last_len_r;  last_v_nxt = last_v_r;  start_nxt = start_r;
    tail_nxt = tail_r;  tail_v_nxt = tail_v_r;  total_nxt = total_r;
    st_nxt = st_r;  pay_nxt = pay_r;  mk_nxt = mk_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt = out_data_r;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;  mem_ra = '0;

    bytes_rnd = {1'b0, in_bytes} + 16'd7;
    has_next  = (cur_r != '1) && !rd_data[LINK_POS] && (rd_data[SZW-1:AW] == '0);
    steps_inc = steps_r + 1'b1;
    rest      = len_r - need_r;
    split     = ({1'b0, len_r} >= {1'b0, need_r} + (LW+1)'(MIN_FREE_WORDS));
    sub_n     = split ? need_r : len_r;
    w_len     = cell_len(rd_data, scan_r[AW-1:0]);
    w_adv     = scan_r + w_len;
    hdr_clr   = rd_data & ~MARK_MASK;
    lm1       = last_len_r - 1'b1;
    e13       = (last_hdr_r[TYPE_LSB-1:EXTRA_LSB] > SZW'(lm1)) ? lm1 :
                last_hdr_r[EXTRA_LSB+LW-1:EXTRA_LSB];
    run       = scan_r - start_r;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_THRESHOLD: thr_nxt = cfg_wdata;
        CFG_ENABLE:    gc_en_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = (clr_r == AW'(0)) ? HDR_INIT : (clr_r == AW'(1)) ? LINK_END : '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          head_nxt = '0;  empty_nxt = 1'b0;  free_nxt = LW'(HEAP_WORDS);
          state_nxt = clr_op_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          st_nxt = ST_OK;  pay_nxt = '0;  mk_nxt = 1'b0;
          case (in_op)
            OP_ALLOC: begin
              need_nxt = LW'(bytes_rnd >> 3) + LW'(HEADER_WORDS);
              type_nxt = in_type;
              cur_nxt = head_r;  prev_v_nxt = 1'b0;  steps_nxt = '0;
              if (empty_r) begin
                st_nxt = ST_EXHAUST;  state_nxt = S_DONE;
              end else begin
                state_nxt = S_A_HDR;
              end
            end
            OP_MARK: begin
              if (in_addr == '0 || in_addr >= 13'(HEAP_WORDS)) begin
                st_nxt = ST_OUTSIDE;  state_nxt = S_DONE;
              end else begin
                addr_nxt = in_addr[AW-1:0] - 1'b1;  state_nxt = S_M_RD;
              end
            end
            OP_SWEEP: begin
              scan_nxt = '0;  tail_v_nxt = 1'b0;  total_nxt = '0;
              ph_nxt = 1'b0;  last_v_nxt = 1'b0;  state_nxt = S_W_RD;
            end
            OP_INIT: begin
              clr_nxt = '0;  clr_op_nxt = 1'b1;  state_nxt = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_A_HDR: begin
        mem_ra = cur_r;  state_nxt = S_A_LNK;
      end
      S_A_LNK: begin
        hdr_nxt = rd_data;
        len_nxt = cell_len(rd_data, cur_r);
        mem_ra = cur_r + 1'b1;
        state_nxt = S_A_EV;
      end
      S_A_EV: begin
        steps_nxt = steps_inc;
        if (len_r >= need_r) begin
          free_nxt = (sub_n > free_r) ? '0 : free_r - sub_n;
          if (split) begin
            mem_we = 1'b1;  mem_wa = cur_r;
            mem_wd = {hdr_r[63:SZW], SZW'(rest)};
            addr_nxt = cur_r + rest[AW-1:0];
            sz_nxt = need_r;  ex_nxt = '0;
          end else begin
            if (prev_v_r) begin
              if (prev_r != '1) begin
                mem_we = 1'b1;  mem_wa = prev_r + 1'b1;
                mem_wd = has_next ? 64'(rd_data[AW-1:0]) : LINK_END;
              end
            end else if (has_next) begin
              head_nxt = rd_data[AW-1:0];
            end else begin
              empty_nxt = 1'b1;
            end
            addr_nxt = cur_r;  sz_nxt = len_r;  ex_nxt = rest;
          end
          state_nxt = S_A_WR2;
        end else if (has_next && !steps_inc[LW-1]) begin
          prev_nxt = cur_r;  prev_v_nxt = 1'b1;
          cur_nxt = rd_data[AW-1:0];  state_nxt = S_A_HDR;
        end else begin
          st_nxt = ST_EXHAUST;  state_nxt = S_DONE;
        end
      end
      S_A_WR2: begin
        mem_we = 1'b1;  mem_wa = addr_r;  mem_wd = compose(sz_r, ex_r, type_r);
        pay_nxt = addr_r + AW'(HEADER_WORDS);
        state_nxt = S_DONE;
      end
      S_M_RD: begin
        mem_ra = addr_r;  state_nxt = S_M_WR;
      end
      S_M_WR: begin
        if (rd_data[MARK_POS]) begin
          mk_nxt = 1'b1;
        end else begin
          mem_we = 1'b1;  mem_wa = addr_r;  mem_wd = rd_data | MARK_MASK;
        end
        state_nxt = S_DONE;
      end
      S_W_RD: begin
        mem_ra = scan_r[AW-1:0];  state_nxt = S_W_EV;
      end
      S_W_EV: begin
        if (!ph_r && rd_data[MARK_POS]) begin
          mem_we = 1'b1;  mem_wa = scan_r[AW-1:0];  mem_wd = hdr_clr;
          last_nxt = scan_r[AW-1:0];  last_hdr_nxt = hdr_clr;
          last_len_nxt = w_len;  last_v_nxt = 1'b1;
          scan_nxt = w_adv;
          state_nxt = w_adv[LW-1] ? S_W_FIN : S_W_RD;
        end else if (ph_r && rd_data[MARK_POS]) begin
          state_nxt = S_R1;
        end else begin
          if (!ph_r) begin
            start_nxt = scan_r;  ph_nxt = 1'b1;
          end
          scan_nxt = w_adv;
          state_nxt = w_adv[LW-1] ? S_R1 : S_W_RD;
        end
      end
      S_R1: begin
        if (last_v_r) begin
          start_nxt = start_r - e13;
          mem_we = 1'b1;  mem_wa = last_r;
          mem_wd = {last_hdr_r[63:TYPE_LSB], SZW'(0), SZW'(last_len_r - e13)};
        end
        state_nxt = S_R2;
      end
      S_R2: begin
        mem_we = 1'b1;  mem_wa = start_r[AW-1:0];  mem_wd = compose(run, '0, FREE_TYPE);
        if (!scan_r[LW-1]) begin
          ph_nxt = 1'b0;  last_v_nxt = 1'b0;
        end
        state_nxt = scan_r[LW-1] ? S_W_FIN : S_W_RD;
        if (run >= LW'(MIN_FREE_WORDS)) begin
          total_nxt = total_r + run;
          if (tail_v_r) begin
            state_nxt = S_R3;
          end else begin
            head_nxt = start_r[AW-1:0];  tail_nxt = start_r[AW-1:0];  tail_v_nxt = 1'b1;
          end
        end
      end
      S_R3: begin
        mem_we = 1'b1;  mem_wa = tail_r + 1'b1;  mem_wd = 64'(start_r);
        tail_nxt = start_r[AW-1:0];
        state_nxt = scan_r[LW-1] ? S_W_FIN : S_W_RD;
      end
      S_W_FIN: begin
        if (tail_v_r) begin
          mem_we = 1'b1;  mem_wa = tail_r + 1'b1;  mem_wd = LINK_END;
        end
        empty_nxt = !tail_v_r;  free_nxt = total_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {3'd0, gc_en_r && (free_r < thr_r), free_r, mk_r,
                          pay_r, st_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;  clr_r <= '0;  clr_op_r <= 1'b0;
      head_r <= '0;  empty_r <= 1'b0;  free_r <= LW'(HEAP_WORDS);
      thr_r <= 13'd2048;  gc_en_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  clr_r <= clr_nxt;  clr_op_r <= clr_op_nxt;
      head_r <= head_nxt;  empty_r <= empty_nxt;  free_r <= free_nxt;
      thr_r <= thr_nxt;  gc_en_r <= gc_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r <= need_nxt;  type_r <= type_nxt;  addr_r <= addr_nxt;
    cur_r <= cur_nxt;  prev_r <= prev_nxt;  prev_v_r <= prev_v_nxt;  steps_r <= steps_nxt;
    hdr_r <= hdr_nxt;  len_r <= len_nxt;  sz_r <= sz_nxt;  ex_r <= ex_nxt;
    scan_r <= scan_nxt;  ph_r <= ph_nxt;  last_r <= last_nxt;  last_hdr_r <= last_hdr_nxt;
    last_len_r <= last_len_nxt;  last_v_r <= last_v_nxt;  start_r <= start_nxt;
    tail_r <= tail_nxt;  tail_v_r <= tail_v_nxt;  total_r <= total_nxt;
    st_r <= st_nxt;  pay_r <= pay_nxt;  mk_r <= mk_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_AT(a_free_max, free_r <= LW'(HEAP_WORDS), "free word count past heap size")
  `ASSERT_AT(a_busy_after_req, in_tvalid && in_tready |=> !in_tready, "request overlap")
  `ASSERT_ALWAYS(a_clear_busy, state_r == S_CLEAR |-> !in_tready, "request during clear")

endmodule
